@@ hdl/sdff_pkg.sv @@
// shared types and constants of the signed decimal field formatter
// no dependencies; compiled before the channel interfaces and the top level
package sdff_pkg;

   localparam int VALUE_W    = 64;
   localparam int FIELD_W    = 6;
   localparam int CHAR_W     = 8;
   localparam int MAX_FIELD  = 60;
   localparam int NUM_DIGITS = 20;
   localparam int MAX_CHARS  = 64;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
   localparam int COUNT_W    = $clog2(MAX_CHARS + 1);
   localparam int CONV_CNT_W = $clog2(VALUE_W);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [FIELD_W-1:0]        field_type;
   typedef logic [CHAR_W-1:0]         char_type;
   typedef logic [BCD_W-1:0]          bcd_type;
   typedef logic [COUNT_W-1:0]        count_type;

   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_MINUS = 8'h2D;

endpackage

@@ hdl/sdff_ifs.sv @@
// request and response channel interfaces of the signed decimal field formatter
// depends on sdff_pkg
interface sdff_req_if;
   import sdff_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   field_type field_width;
   field_type min_digits;
   logic      force_plus;
   logic      space_sign;
   logic      zero_pad;
   logic      left_justify;

   modport source (
      output valid, value, field_width, min_digits, force_plus, space_sign, zero_pad,
         left_justify,
      input  ready
   );
   modport sink (
      input  valid, value, field_width, min_digits, force_plus, space_sign, zero_pad,
         left_justify,
      output ready
   );
endinterface

interface sdff_rsp_if;
   import sdff_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_code;
   logic     last_char;

   modport source (output valid, char_code, last_char, input ready);
   modport sink   (input valid, char_code, last_char, output ready);
endinterface

@@ hdl/signed_decimal_field_formatter.sv @@
// signed_decimal_field_formatter: formats one signed 64-bit value as a printf-style
// decimal field (width, precision, plus / space / zero / left-justify flags) and sends
// it out one ASCII character per response transaction, the final one flagged by
// last_char. One request is handled at a time. A request is taken in the idle state, the
// magnitude is converted to BCD by a bit-serial shift-and-add-3 loop (one magnitude bit
// per cycle), leading zero digits are stripped one digit per cycle, a setup state works
// out the pad counts, and then one character leaves per cycle while the consumer keeps
// ready high (up to 61 characters). The conversion loop dominates for short fields.
// The response register lets the next request be taken while the final character
// still waits to be taken.
// depends on sdff_pkg and sdff_ifs
module signed_decimal_field_formatter (
   input logic      clock,
   input logic      reset,
   sdff_req_if.sink req,
   sdff_rsp_if.source rsp
);
   import sdff_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CONV  = 5'b00010,
      ST_NORM  = 5'b00100,
      ST_SETUP = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // control state
   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // request copy, conversion and emission datapath
   logic [VALUE_W-1:0]      mag_ff, mag_in;
   logic [CONV_CNT_W-1:0]   conv_cnt_ff, conv_cnt_in;
   bcd_type                 bcd_ff, bcd_in;
   logic [NDIG_W-1:0]       ndig_ff, ndig_in;
   field_type               fw_ff, fw_in;
   field_type               prec_ff, prec_in;
   logic                    neg_ff, neg_in;
   logic                    plus_ff, plus_in;
   logic                    space_ff, space_in;
   logic                    zero_ff, zero_in;
   logic                    left_ff, left_in;
   count_type               spaces_ff, spaces_in;
   count_type               zeros_ff, zeros_in;
   count_type               remain_ff, remain_in;
   logic                    sign_pend_ff, sign_pend_in;
   char_type                sign_code_ff, sign_code_in;
   char_type                char_ff, char_in;
   logic                    last_ff, last_in;

   // add 3 to every bcd digit of 5 or more before the shift
   function automatic bcd_type dabble_adjust(input bcd_type b);
      bcd_type r;
      r = b;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (b[4*i +: 4] >= 4'd5) begin
            r[4*i +: 4] = b[4*i +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   bcd_type   bcd_adj;
   assign bcd_adj = dabble_adjust(bcd_ff);

   // field lengths, all in count width
   count_type ndig_w, prec_w, fw_w, maxlen_w, len_w, placed_w;
   count_type spaces_calc, zeros_calc;
   logic      has_sign, suppress_spaces;
   char_type  sign_calc;

   always_comb begin
      ndig_w   = COUNT_W'(ndig_ff);
      prec_w   = COUNT_W'(prec_ff);
      fw_w     = COUNT_W'(fw_ff);
      maxlen_w = (prec_w > ndig_w) ? prec_w : ndig_w;
      // at most one sign character: minus, plus, or a leading space
      has_sign = neg_ff | plus_ff | (space_ff & ~left_ff);
      len_w    = maxlen_w + COUNT_W'(has_sign);
      // zero padding to the width takes the place of space padding
      suppress_spaces = zero_ff & (prec_ff == '0) & ~left_ff;
      // the leading space sign is not counted when zero padding to the width
      placed_w = ndig_w + COUNT_W'(plus_ff | neg_ff);
      spaces_calc = (!suppress_spaces && (fw_w > len_w)) ? (fw_w - len_w) : '0;
      if (prec_ff != '0) begin
         zeros_calc = (prec_w > ndig_w) ? (prec_w - ndig_w) : '0;
      end else if (suppress_spaces && (fw_w > placed_w)) begin
         zeros_calc = fw_w - placed_w;
      end else begin
         zeros_calc = '0;
      end
      if (neg_ff) begin
         sign_calc = CH_MINUS;
      end else if (plus_ff) begin
         sign_calc = CH_PLUS;
      end else begin
         sign_calc = CH_SPACE;
      end
   end

   // a character leaves when the response register is free or being drained
   logic emit_go;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   field_type req_fw_sat, req_prec_sat;
   assign req_fw_sat   = (req.field_width > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                                  : req.field_width;
   assign req_prec_sat = (req.min_digits > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                                 : req.min_digits;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      mag_in       = mag_ff;
      conv_cnt_in  = conv_cnt_ff;
      bcd_in       = bcd_ff;
      ndig_in      = ndig_ff;
      fw_in        = fw_ff;
      prec_in      = prec_ff;
      neg_in       = neg_ff;
      plus_in      = plus_ff;
      space_in     = space_ff;
      zero_in      = zero_ff;
      left_in      = left_ff;
      spaces_in    = spaces_ff;
      zeros_in     = zeros_ff;
      remain_in    = remain_ff;
      sign_pend_in = sign_pend_ff;
      sign_code_in = sign_code_ff;
      char_in      = char_ff;
      last_in      = last_ff;

      // response register drains on its own handshake
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               neg_in      = req.value[VALUE_W-1];
               mag_in      = req.value[VALUE_W-1] ? (~req.value + 1'b1) : req.value;
               fw_in       = req_fw_sat;
               prec_in     = req_prec_sat;
               plus_in     = req.force_plus;
               space_in    = req.space_sign;
               zero_in     = req.zero_pad;
               left_in     = req.left_justify;
               bcd_in      = '0;
               conv_cnt_in = '0;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            // one magnitude bit into the bcd register per cycle
            bcd_in      = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in      = {mag_ff[VALUE_W-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == CONV_CNT_W'(VALUE_W - 1)) begin
               ndig_in  = NDIG_W'(NUM_DIGITS);
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // strip leading zero digits, keeping at least one
            if ((ndig_ff > NDIG_W'(1)) && (bcd_ff[BCD_W-1 -: 4] == 4'd0)) begin
               bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            spaces_in    = spaces_calc;
            zeros_in     = zeros_calc;
            sign_pend_in = has_sign;
            sign_code_in = sign_calc;
            remain_in    = spaces_calc + COUNT_W'(has_sign) + zeros_calc + ndig_w;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               last_in      = (remain_ff == COUNT_W'(1));
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
               // order: spaces, sign, zeros, digits; spaces go last when left-justified
               if (!left_ff && (spaces_ff != '0)) begin
                  char_in   = CH_SPACE;
                  spaces_in = spaces_ff - 1'b1;
               end else if (sign_pend_ff) begin
                  char_in      = sign_code_ff;
                  sign_pend_in = 1'b0;
               end else if (zeros_ff != '0) begin
                  char_in  = CH_ZERO;
                  zeros_in = zeros_ff - 1'b1;
               end else if (ndig_ff != '0) begin
                  char_in = CH_ZERO + CHAR_W'(bcd_ff[BCD_W-1 -: 4]);
                  bcd_in  = {bcd_ff[BCD_W-5:0], 4'd0};
                  ndig_in = ndig_ff - 1'b1;
               end else begin
                  char_in   = CH_SPACE;
                  spaces_in = spaces_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      conv_cnt_ff  <= conv_cnt_in;
      bcd_ff       <= bcd_in;
      ndig_ff      <= ndig_in;
      fw_ff        <= fw_in;
      prec_ff      <= prec_in;
      neg_ff       <= neg_in;
      plus_ff      <= plus_in;
      space_ff     <= space_in;
      zero_ff      <= zero_in;
      left_ff      <= left_in;
      spaces_ff    <= spaces_in;
      zeros_ff     <= zeros_in;
      remain_ff    <= remain_in;
      sign_pend_ff <= sign_pend_in;
      sign_code_ff <= sign_code_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last_char = last_ff;

`ifndef NO_ASSERTIONS
   // a taken request always starts the conversion loop
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == ST_CONV))
      else $error("request taken without starting conversion");

   // the character count never runs out while still emitting
   a_emit_has_chars: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("emitting with no characters left");

   // the final character is flagged and the block returns to idle
   a_last_flagged: assert property (@(posedge clock) disable iff (reset)
      (emit_go && (remain_ff == COUNT_W'(1)))
         |=> (rsp.valid && rsp.last_char && (state_ff == ST_IDLE)))
      else $error("final character not flagged");

   // digit count stays within the bcd register once stripped
   a_ndig_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |-> ((ndig_ff != '0) && (ndig_ff <= NDIG_W'(NUM_DIGITS))))
      else $error("digit count out of range");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking testbench of signed_decimal_field_formatter: directed and random
// requests, a built-in field predictor, and a character-by-character response check
// depends on sdff_pkg, sdff_ifs and the signed_decimal_field_formatter top level
module tb;
   import sdff_pkg::*;

   // one request as the driver puts it on the channel
   typedef struct {
      value_type value;
      field_type field_width;
      field_type min_digits;
      logic      force_plus;
      logic      space_sign;
      logic      zero_pad;
      logic      left_justify;
   } field_request_type;

   // one predicted character of a formatted field
   typedef struct {
      char_type code;
      logic     last;
   } field_char_type;

   // watchdog limit for the whole run, with a wide margin over the slowest legal run
   localparam int CYCLE_LIMIT   = 2_000_000;
   // quiet tail after the last character has come back
   localparam int DRAIN_CYCLES  = 300;
   localparam int RANDOM_ITEMS  = 370;
   // percent of cycles in which each side holds off
   localparam int IDLE_PERCENT  = 36;
   // window of accepted requests during which neither side idles
   localparam int STEADY_FIRST  = 180;
   localparam int STEADY_LAST   = 260;

   localparam value_type MAX_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam value_type MOST_NEG = 64'sh8000_0000_0000_0000;

   logic clock = 1'b0;
   logic reset;

   sdff_req_if req_if ();
   sdff_rsp_if rsp_if ();

   signed_decimal_field_formatter u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   field_request_type pending_requests[$];
   field_char_type    expected_chars[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  requests_taken = 0;
   int  chars_checked  = 0;
   // set at the rising edge when the request on the channel was taken
   logic req_took = 1'b0;

   // both sides run without idling inside this window
   wire steady = (requests_taken >= STEADY_FIRST) && (requests_taken < STEADY_LAST);

   initial begin
      forever #4 clock = ~clock;
   end

   // one line per mismatch, counted for the final verdict
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch on character %0d: %s", $realtime, chars_checked, what);
   endtask

   // works out every character of the field for one request and queues them in order
   task automatic format_decimal_field(input field_request_type rq);
      logic           neg;
      logic [63:0]    mag;
      int             digs[20];
      int             ndig;
      int             fw;
      int             prec;
      int             len;
      int             placed;
      int             pad;
      logic           plus_on;
      logic           space_on;
      char_type       body[$];
      char_type       field[$];
      field_char_type fc;

      neg  = rq.value[VALUE_W-1];
      // two's complement magnitude, exact for the most negative value too
      mag  = neg ? (~rq.value + 64'd1) : rq.value;
      fw   = (int'(rq.field_width) > MAX_FIELD) ? MAX_FIELD : int'(rq.field_width);
      prec = (int'(rq.min_digits) > MAX_FIELD) ? MAX_FIELD : int'(rq.min_digits);

      // least significant digit first; zero still gives one digit
      ndig = 0;
      do begin
         digs[ndig] = int'(mag % 64'd10);
         ndig++;
         mag = mag / 64'd10;
      end while (mag != 0 && ndig < NUM_DIGITS);

      plus_on  = rq.force_plus && !neg;
      // a space sign loses to plus and to left-justify
      space_on = rq.space_sign && !rq.force_plus && !rq.left_justify && !neg;

      // printed length without padding spaces
      len = (prec > ndig) ? prec : ndig;
      len += int'(neg) + int'(plus_on || space_on);

      if (plus_on) body.push_back(CH_PLUS);
      if (space_on) body.push_back(CH_SPACE);
      if (neg) body.push_back(CH_MINUS);

      // zero fill count: '+' counts only without precision, '-' only when zero
      // padding without precision, a space sign never (field grows by one)
      placed = ndig + int'(plus_on && prec == 0) + int'(neg && rq.zero_pad && prec == 0);
      while ((rq.zero_pad && placed < fw && prec == 0 && !rq.left_justify) ||
             placed < prec) begin
         body.push_back(CH_ZERO);
         placed++;
      end
      for (int d = ndig - 1; d >= 0; d--) body.push_back(char_type'(CH_ZERO + digs[d]));

      pad = 0;
      if (fw != 0) begin
         // zero padding to the width takes the place of all space padding
         if (rq.zero_pad && prec == 0 && !rq.left_justify) len = fw;
         if (len < fw) pad = fw - len;
      end

      if (!rq.left_justify) begin
         repeat (pad) field.push_back(CH_SPACE);
      end
      foreach (body[i]) field.push_back(body[i]);
      if (rq.left_justify) begin
         repeat (pad) field.push_back(CH_SPACE);
      end

      foreach (field[i]) begin
         fc.code = field[i];
         fc.last = (i == field.size() - 1);
         expected_chars.push_back(fc);
      end
   endtask

   function automatic field_request_type make_request(input value_type v, input int fw,
                                                      input int prec,
                                                      input logic [3:0] flags);
      field_request_type rq;
      rq.value        = v;
      rq.field_width  = field_type'(fw);
      rq.min_digits   = field_type'(prec);
      // flags ordered plus, space, zero, left
      rq.force_plus   = flags[3];
      rq.space_sign   = flags[2];
      rq.zero_pad     = flags[1];
      rq.left_justify = flags[0];
      return rq;
   endfunction

   // random value with a spread of digit counts, sign chosen separately
   function automatic value_type random_value();
      logic [63:0] raw;
      logic [63:0] mag;
      logic [63:0] pow;
      int          k;
      raw = {$urandom, $urandom};
      if ($urandom_range(3) == 0) begin
         // full 64-bit pattern, may hit the most negative value
         return value_type'(raw);
      end
      k = $urandom_range(1, 18);
      pow = 64'd1;
      repeat (k) pow = pow * 64'd10;
      mag = {1'b0, raw[62:0]} % pow;
      return $urandom_range(1) ? -value_type'(mag) : value_type'(mag);
   endfunction

   // mostly short widths and precisions, sometimes the full 6-bit range
   function automatic int random_width(input int zero_weight);
      int r;
      r = $urandom_range(9);
      if (r < zero_weight) return 0;
      if (r < 8) return $urandom_range(0, 24);
      return $urandom_range(0, 63);
   endfunction

   // request driver: presents the next pending request at the falling edge
   always @(negedge clock) begin
      field_request_type rq;
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.value        <= '0;
         req_if.field_width  <= '0;
         req_if.min_digits   <= '0;
         req_if.force_plus   <= 1'b0;
         req_if.space_sign   <= 1'b0;
         req_if.zero_pad     <= 1'b0;
         req_if.left_justify <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (pending_requests.size() != 0 &&
             (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
            rq = pending_requests.pop_front();
            req_if.value        <= rq.value;
            req_if.field_width  <= rq.field_width;
            req_if.min_digits   <= rq.min_digits;
            req_if.force_plus   <= rq.force_plus;
            req_if.space_sign   <= rq.space_sign;
            req_if.zero_pad     <= rq.zero_pad;
            req_if.left_justify <= rq.left_justify;
            req_if.valid        <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response consumer: ready stalls at random outside the steady window
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // monitor: checks each response transaction, then predicts each taken request
   always @(posedge clock) begin
      field_request_type rq;
      field_char_type    want;
      req_took <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_if.char_code, rsp_if.last_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.char_code !== want.code)
                  report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                            rsp_if.char_code, want.code));
               if (rsp_if.last_char !== want.last)
                  report_mismatch($sformatf("last_char %0b, want %0b",
                                            rsp_if.last_char, want.last));
            end
            chars_checked++;
         end
         if (req_if.valid && req_if.ready) begin
            rq.value        = req_if.value;
            rq.field_width  = req_if.field_width;
            rq.min_digits   = req_if.min_digits;
            rq.force_plus   = req_if.force_plus;
            rq.space_sign   = req_if.space_sign;
            rq.zero_pad     = req_if.zero_pad;
            rq.left_justify = req_if.left_justify;
            format_decimal_field(rq);
            requests_taken++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      // channel inputs get known values from the drivers while reset is high
      reset = 1'b1;

      // directed: zero, extremes, each flag and the padding corner cases
      pending_requests.push_back(make_request(0, 0, 0, 4'b0000));
      // zero padded to the width
      pending_requests.push_back(make_request(0, 5, 0, 4'b0010));
      pending_requests.push_back(make_request(1, 0, 0, 4'b1000));
      // negative with zero padding counts the minus
      pending_requests.push_back(make_request(-1, 6, 0, 4'b0010));
      pending_requests.push_back(make_request(MAX_POS, 0, 0, 4'b0000));
      // width above the cap saturates
      pending_requests.push_back(make_request(-MAX_POS, 63, 0, 4'b0000));
      // most negative value keeps its exact magnitude
      pending_requests.push_back(make_request(MOST_NEG, 0, 0, 4'b0000));
      pending_requests.push_back(make_request(MOST_NEG, 30, 0, 4'b0010));
      // space sign with zero padding comes out one wider than the width
      pending_requests.push_back(make_request(42, 8, 0, 4'b0110));
      pending_requests.push_back(make_request(42, 8, 0, 4'b0100));
      // left-justify drops the space sign
      pending_requests.push_back(make_request(42, 8, 0, 4'b0101));
      pending_requests.push_back(make_request(-123, 10, 0, 4'b0001));
      pending_requests.push_back(make_request(123, 10, 0, 4'b1001));
      // precision pads digits; zero flag ignored with a precision
      pending_requests.push_back(make_request(123, 0, 6, 4'b0000));
      pending_requests.push_back(make_request(-123, 12, 6, 4'b0010));
      // precision above the cap saturates
      pending_requests.push_back(make_request(7, 0, 63, 4'b1000));
      pending_requests.push_back(make_request(123, 60, 60, 4'b0000));
      pending_requests.push_back(make_request(-123, 63, 63, 4'b1111));
      // zero flag ignored with left-justify
      pending_requests.push_back(make_request(5, 3, 0, 4'b0011));
      // width smaller than the number
      pending_requests.push_back(make_request(99999, 2, 0, 4'b0000));
      // plus wins over space
      pending_requests.push_back(make_request(0, 0, 0, 4'b1100));
      // no space sign for negatives
      pending_requests.push_back(make_request(-5, 4, 0, 4'b0100));
      // plus counted in the zero fill
      pending_requests.push_back(make_request(1234567890, 63, 0, 4'b1010));
      pending_requests.push_back(make_request(-9, 1, 1, 4'b1111));

      // random part
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_requests.push_back(make_request(random_value(), random_width(3),
                                                 random_width(5), 4'($urandom_range(15))));
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests taken, all characters back, then a quiet tail
      while (pending_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
